### rtl/core/bcw_pkg.sv
// Shared types and constants for the boundary condition wrap block.
package bcw_pkg;

  localparam int SIZE_BITS     = 31;
  localparam int DIV_BITS      = SIZE_BITS + 1;
  localparam int REM_BITS      = DIV_BITS + 1;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = SIZE_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_HEIGHT = 2'd2;

  typedef enum logic [1:0] {
    MODE_ABSORB   = 2'd0,
    MODE_REFLECT  = 2'd1,
    MODE_PERIODIC = 2'd2,
    MODE_PASS     = 2'd3
  } mode_e;

  localparam logic [SIZE_BITS-1:0] SIZE_RESET = 31'd6553600;

endpackage

### rtl/core/boundary_condition_wrap.sv
// Boundary condition wrap: periodic, reflective and absorbing position correction.
// Reflective/periodic: the result is set by the shared radix-2 remainder unit, x then y.
// Absorbing: the remainder steps are skipped; unsupported mode: no correction is done.
// A finished result sits in the output register while the next transaction is taken.
// Reset: async active low; mode periodic, width and height 100.0, no result pending.
module boundary_condition_wrap #(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [bcw_pkg::CFG_IDX_BITS-1:0]       cfg_idx_i,
  input  logic [bcw_pkg::CFG_DATA_BITS-1:0]      cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [COORD_BITS-1:0]           x_in_i,
  input  logic signed [COORD_BITS-1:0]           y_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [COORD_BITS-1:0]           x_out_o,
  output logic signed [COORD_BITS-1:0]           y_out_o,
  output logic                                   absorbed_o,
  output logic                                   bad_mode_o
);

  localparam int SB     = bcw_pkg::SIZE_BITS;
  localparam int DB     = bcw_pkg::DIV_BITS;
  localparam int RB     = bcw_pkg::REM_BITS;
  localparam int EXT_W  = COORD_BITS + DB;
  localparam int CNT_W  = $clog2(COORD_BITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_BITS - 1);
  localparam logic [63:0] ONE_WIDE = 64'd1 << FRAC_BITS;
  localparam logic [COORD_BITS-1:0] MINUS_ONE = COORD_BITS'(~ONE_WIDE + 64'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIX  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  bcw_pkg::mode_e   mode_q;
  logic [SB-1:0]    width_q, height_q;

  logic [2:0]            state_q, state_d;
  logic                  cur_q, cur_d;
  logic [COORD_BITS-1:0] x_q, x_d, y_q, y_d;
  logic [COORD_BITS-1:0] xr_q, xr_d, yr_q, yr_d;
  logic                  neg_q, neg_d, outside_q, outside_d;
  logic                  absorbed_q, absorbed_d, bad_q, bad_d;
  logic [COORD_BITS-1:0] dvd_q, dvd_d;
  logic [RB-1:0]         rem_q, rem_d;
  logic [DB-1:0]         dsr_q, dsr_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;

  logic                  out_valid_q;
  logic [COORD_BITS-1:0] x_out_q, y_out_q;
  logic                  absorbed_out_q, bad_out_q;

  logic                  in_acc, out_load;
  logic [COORD_BITS-1:0] raw;
  logic [SB-1:0]         size_sel;
  logic                  raw_neg;
  logic [COORD_BITS-1:0] raw_mag;
  logic [RB-1:0]         rem_sh;
  logic [RB:0]           trial;
  logic [DB-1:0]         rem_lo, refl_res, wrap_res;
  logic [COORD_BITS-1:0] fix_res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bcw_pkg::MODE_PERIODIC;
      width_q  <= bcw_pkg::SIZE_RESET;
      height_q <= bcw_pkg::SIZE_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bcw_pkg::REG_MODE:   mode_q   <= bcw_pkg::mode_e'(cfg_data_i[1:0]);
        bcw_pkg::REG_WIDTH:  width_q  <= cfg_data_i;
        bcw_pkg::REG_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);

  // current coordinate
  assign raw      = cur_q ? y_q : x_q;
  assign size_sel = cur_q ? height_q : width_q;
  assign raw_neg  = raw[COORD_BITS-1];
  assign raw_mag  = raw_neg ? (~raw + COORD_BITS'(1)) : raw;

  // shared remainder step
  assign rem_sh = {rem_q[RB-2:0], dvd_q[COORD_BITS-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, dsr_q};

  // fold and wrap correction
  assign rem_lo = rem_q[DB-1:0];
  always_comb begin
    if (size_sel == '0) begin
      refl_res = '0;
    end else if (rem_lo > {1'b0, size_sel}) begin
      refl_res = {size_sel, 1'b0} - rem_lo;
    end else begin
      refl_res = rem_lo;
    end
    if (size_sel == '0) begin
      wrap_res = '0;
    end else if (neg_q) begin
      wrap_res = (rem_lo == '0) ? '0 : ({1'b0, size_sel} - rem_lo);
    end else begin
      wrap_res = (rem_lo == '0) ? {1'b0, size_sel} : rem_lo;
    end
    if (mode_q == bcw_pkg::MODE_REFLECT) begin
      fix_res = COORD_BITS'(refl_res);
    end else if (mode_q == bcw_pkg::MODE_PERIODIC && outside_q) begin
      fix_res = COORD_BITS'(wrap_res);
    end else begin
      fix_res = raw;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    x_d        = x_q;
    y_d        = y_q;
    xr_d       = xr_q;
    yr_d       = yr_q;
    neg_d      = neg_q;
    outside_d  = outside_q;
    absorbed_d = absorbed_q;
    bad_d      = bad_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    dsr_d      = dsr_q;
    cnt_d      = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          x_d        = x_in_i;
          y_d        = y_in_i;
          xr_d       = x_in_i;
          yr_d       = y_in_i;
          cur_d      = 1'b0;
          absorbed_d = 1'b0;
          bad_d      = (mode_q == bcw_pkg::MODE_PASS);
          state_d    = (mode_q == bcw_pkg::MODE_PASS) ? S_DONE : S_LOAD;
        end
      end
      S_LOAD: begin
        neg_d     = raw_neg;
        outside_d = raw_neg || (EXT_W'(raw) > EXT_W'(size_sel));
        dvd_d     = raw_mag;
        rem_d     = '0;
        dsr_d     = (mode_q == bcw_pkg::MODE_REFLECT) ? {size_sel, 1'b0} : {1'b0, size_sel};
        cnt_d     = CNT_LAST;
        state_d   = (mode_q == bcw_pkg::MODE_ABSORB) ? S_FIX : S_DIV;
      end
      S_DIV: begin
        dvd_d = {dvd_q[COORD_BITS-2:0], 1'b0};
        rem_d = trial[RB] ? rem_sh : trial[RB-1:0];
        cnt_d = cnt_q - CNT_W'(1);
        if (cnt_q == '0) begin
          state_d = S_FIX;
        end
      end
      S_FIX: begin
        if (mode_q == bcw_pkg::MODE_ABSORB) begin
          absorbed_d = absorbed_q | outside_q;
        end
        if (cur_q) begin
          yr_d    = fix_res;
          state_d = S_DONE;
        end else begin
          xr_d    = fix_res;
          cur_d   = 1'b1;
          state_d = S_LOAD;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cur_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_q       <= cur_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    y_q        <= y_d;
    xr_q       <= xr_d;
    yr_q       <= yr_d;
    neg_q      <= neg_d;
    outside_q  <= outside_d;
    absorbed_q <= absorbed_d;
    bad_q      <= bad_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    dsr_q      <= dsr_d;
    cnt_q      <= cnt_d;
    if (out_load) begin
      x_out_q        <= absorbed_q ? MINUS_ONE : xr_q;
      y_out_q        <= absorbed_q ? MINUS_ONE : yr_q;
      absorbed_out_q <= absorbed_q;
      bad_out_q      <= bad_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign x_out_o     = x_out_q;
  assign y_out_o     = y_out_q;
  assign absorbed_o  = absorbed_out_q;
  assign bad_mode_o  = bad_out_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && dsr_q != '0) |-> (rem_q < {1'b0, dsr_q}))
    else $error("remainder not below divisor");

  a_absorb_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && absorbed_o) |-> (x_out_o == MINUS_ONE && y_out_o == MINUS_ONE))
    else $error("absorbed result not minus one");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(absorbed_o && bad_mode_o))
    else $error("absorbed and bad mode together");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q != S_IDLE))
    else $error("accepted transaction not started");

endmodule

### verif/bcw_position_checker.sv
// Checker for the boundary condition wrap block: predicts each position and compares results.
module bcw_position_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [bcw_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [bcw_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                              in_valid_i,
  input  logic                              in_stall_i,
  input  logic [31:0]                       x_in_i,
  input  logic [31:0]                       y_in_i,
  input  logic                              out_valid_i,
  input  logic                              out_stall_i,
  input  logic [31:0]                       x_out_i,
  input  logic [31:0]                       y_out_i,
  input  logic                              absorbed_i,
  input  logic                              bad_mode_i,
  output int                                pending_o,
  output int                                fail_count_o
);
  import bcw_pkg::*;

  localparam logic [31:0] MINUS_ONE = 32'hFFFF_0000;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic        absorbed;
    logic        bad_mode;
  } position_t;

  position_t             corrected_q[$];
  mode_e                 mode_q;
  logic [SIZE_BITS-1:0]  width_q;
  logic [SIZE_BITS-1:0]  height_q;

  function automatic logic outside_arena(logic [31:0] c, logic [SIZE_BITS-1:0] size);
    return c[31] || (c > {1'b0, size});
  endfunction

  function automatic logic [31:0] reflect_coord(logic [31:0] c, logic [SIZE_BITS-1:0] size);
    logic [31:0]       m;
    longint unsigned   mag;
    longint unsigned   period;
    longint unsigned   r;
    if (size == 0) return '0;
    m = c[31] ? -c : c;
    mag = 64'(m);
    period = 64'(size);
    period = period * 2;
    r = mag % period;
    if (r > 64'(size)) r = period - r;
    return r[31:0];
  endfunction

  function automatic logic [31:0] wrap_coord(logic [31:0] c, logic [SIZE_BITS-1:0] size);
    logic [31:0] m;
    logic [31:0] r;
    if (!outside_arena(c, size)) return c;
    if (size == 0) return '0;
    m = c[31] ? -c : c;
    r = m % {1'b0, size};
    if (c[31]) return (r != 0) ? {1'b0, size} - r : '0;
    return (r != 0) ? r : {1'b0, size};
  endfunction

  function automatic position_t correct_position(logic [31:0] x, logic [31:0] y);
    position_t p;
    p = '{x: x, y: y, absorbed: 1'b0, bad_mode: 1'b0};
    case (mode_q)
      MODE_ABSORB: begin
        if (outside_arena(x, width_q) || outside_arena(y, height_q)) begin
          p.x = MINUS_ONE;
          p.y = MINUS_ONE;
          p.absorbed = 1'b1;
        end
      end
      MODE_REFLECT: begin
        p.x = reflect_coord(x, width_q);
        p.y = reflect_coord(y, height_q);
      end
      MODE_PERIODIC: begin
        p.x = wrap_coord(x, width_q);
        p.y = wrap_coord(y, height_q);
      end
      default: p.bad_mode = 1'b1;
    endcase
    return p;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, $signed(want), $signed(got));
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    position_t want;
    if (!rst_ni) begin
      mode_q = MODE_PERIODIC;
      width_q = SIZE_RESET;
      height_q = SIZE_RESET;
      corrected_q.delete();
      pending_o = 0;
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (corrected_q.size() == 0) begin
          $error("result transaction with no pending input");
          fail_count_o++;
        end else begin
          want = corrected_q.pop_front();
          check_field("x_out", want.x, x_out_i);
          check_field("y_out", want.y, y_out_i);
          check_field("absorbed", 32'(want.absorbed), 32'(absorbed_i));
          check_field("bad_mode", 32'(want.bad_mode), 32'(bad_mode_i));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        corrected_q = {corrected_q, correct_position(x_in_i, y_in_i)};
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_MODE:   mode_q = mode_e'(cfg_data_i[1:0]);
          REG_WIDTH:  width_q = cfg_data_i[SIZE_BITS-1:0];
          REG_HEIGHT: height_q = cfg_data_i[SIZE_BITS-1:0];
          default: ;
        endcase
      end
      pending_o = corrected_q.size();
    end
  end

endmodule

### verif/tb_top.sv
// Testbench top for the boundary condition wrap block: stimulus, flow control and verdict.
module tb_top;
  import bcw_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int HOLD_CYCLES  = 400;
  localparam int PHASES       = 12;
  localparam int PHASE_ITEMS  = 92;
  localparam logic [SIZE_BITS-1:0] SIZE_MAX = 31'h7FFF_FFFF;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_we_i;
  logic [CFG_IDX_BITS-1:0]   cfg_idx_i;
  logic [CFG_DATA_BITS-1:0]  cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic signed [31:0]        x_in_i;
  logic signed [31:0]        y_in_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic signed [31:0]        x_out_o;
  logic signed [31:0]        y_out_o;
  logic                      absorbed_o;
  logic                      bad_mode_o;

  int pending;
  int fail_count;
  int idle_cycles;
  bit quiet;
  bit long_hold;

  boundary_condition_wrap uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .x_in_i     (x_in_i),
    .y_in_i     (y_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .x_out_o    (x_out_o),
    .y_out_o    (y_out_o),
    .absorbed_o (absorbed_o),
    .bad_mode_o (bad_mode_o)
  );

  bcw_position_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .x_in_i      (x_in_i),
    .y_in_i      (y_in_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .x_out_i     (x_out_o),
    .y_out_i     (y_out_o),
    .absorbed_i  (absorbed_o),
    .bad_mode_i  (bad_mode_o),
    .pending_o   (pending),
    .fail_count_o(fail_count)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // result side: random stall per transaction, plus one long hold-off on request
  initial begin
    int gap;
    bit held;
    out_stall_i = 1'b0;
    held = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (long_hold && !held) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        held = 1'b1;
      end
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap != 0) begin
        out_stall_i = 1'b1;
        repeat (gap) @(negedge clk_i);
      end
      out_stall_i = 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = data;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic wait_for_results();
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic set_arena(mode_e m, logic [SIZE_BITS-1:0] w, logic [SIZE_BITS-1:0] h);
    wait_for_results();
    write_reg(REG_MODE, CFG_DATA_BITS'(m));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  task automatic offer_position(logic [31:0] x, logic [31:0] y);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    x_in_i = x;
    y_in_i = y;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic logic [SIZE_BITS-1:0] pick_size();
    case ($urandom_range(0, 7))
      0: return SIZE_BITS'($urandom_range(1, 16));
      1: return SIZE_BITS'(65536 * $urandom_range(1, 200));
      2: return SIZE_BITS'($urandom >> 1);
      3: return SIZE_MAX;
      4: return SIZE_BITS'(1);
      5: return SIZE_BITS'($urandom_range(1, 20'hFFFFF));
      6: return '0;
      default: return SIZE_RESET;
    endcase
  endfunction

  // mostly coordinates around the arena edges and multiples of its size
  function automatic logic [31:0] pick_coord(logic [SIZE_BITS-1:0] size);
    longint span;
    longint v;
    int     k;
    span = longint'(size);
    case ($urandom_range(0, 4))
      0: v = longint'($urandom);
      1: v = longint'($urandom_range(0, 32'(size)));
      2: begin
        k = int'($urandom_range(0, 8)) - 4;
        v = longint'(k) * span + longint'(int'($urandom_range(0, 4)) - 2);
      end
      3: begin
        case ($urandom_range(0, 5))
          0: v = 64'sd0;
          1: v = span;
          2: v = -64'sd1;
          3: v = span + 64'sd1;
          4: v = 64'sd2147483647;
          default: v = -64'sd2147483648;
        endcase
      end
      default: v = longint'($urandom_range(0, 65535)) * span / 64'sd4096 - 64'sd8 * span;
    endcase
    return v[31:0];
  endfunction

  initial begin
    logic [SIZE_BITS-1:0] w;
    logic [SIZE_BITS-1:0] h;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = REG_MODE;
    cfg_data_i = '0;
    in_valid_i = 1'b0;
    x_in_i = '0;
    y_in_i = '0;
    quiet = 1'b0;
    long_hold = 1'b0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // reset settings: periodic, 100.0 by 100.0
    offer_position(32'd0, 32'd6553600);
    offer_position(-32'sd6553600, 32'd19660800);
    offer_position(32'h7FFF_FFFF, 32'h8000_0000);
    offer_position(-32'sd1, 32'd6553601);

    set_arena(MODE_REFLECT, SIZE_RESET, 31'd1);
    offer_position(32'd6553600, 32'd1);
    offer_position(32'd0, 32'd0);
    offer_position(32'h8000_0000, 32'h7FFF_FFFF);
    offer_position(-32'sd9830400, 32'd3);

    set_arena(MODE_ABSORB, SIZE_MAX, SIZE_RESET);
    offer_position(32'h7FFF_FFFF, 32'd6553600);
    offer_position(32'd0, 32'd0);
    offer_position(-32'sd1, 32'd0);
    offer_position(32'd5, 32'd6553601);

    set_arena(MODE_PASS, SIZE_RESET, SIZE_RESET);
    offer_position(32'h8000_0000, 32'h7FFF_FFFF);
    offer_position(32'd123, -32'sd456);

    // collapsed arena
    set_arena(MODE_REFLECT, '0, '0);
    offer_position(32'd0, 32'd5);
    offer_position(32'h8000_0000, 32'h7FFF_FFFF);
    set_arena(MODE_PERIODIC, '0, '0);
    offer_position(32'd0, -32'sd3);
    offer_position(32'h7FFF_FFFF, 32'd0);
    set_arena(MODE_ABSORB, '0, '0);
    offer_position(32'd0, 32'd0);
    offer_position(32'd0, 32'd1);

    for (int p = 0; p < PHASES; p++) begin
      w = pick_size();
      h = pick_size();
      set_arena(mode_e'(p % 4), w, h);
      quiet = ($urandom_range(0, 3) == 0);
      if (p == 2) long_hold = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) offer_position(pick_coord(w), pick_coord(h));
    end

    quiet = 1'b0;
    wait_for_results();
    repeat (100) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
